FILE: rtl/mf3_pkg.sv
// shared types, constants and compare helpers for the 3x3 median filter
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 10;
    localparam int FW_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0]  FW_RESET = FW_W'(640);
    localparam logic [ROW_W-1:0] FH_RESET = ROW_W'(480);
    localparam logic [FW_W-1:0]  FW_MIN   = FW_W'(3);
    localparam logic [FW_W-1:0]  FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] FH_MIN   = ROW_W'(3);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } trio_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        pix_t  median;
        meta_t meta;
    } result_t;

    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t  x;
        pix_t  y;
        pix_t  z;
        pix_t  t;
        trio_t s;
        x = a;
        y = b;
        z = c;
        if (x > y) begin
            t = x; x = y; y = t;
        end
        if (y > z) begin
            t = y; y = z; z = t;
        end
        if (x > y) begin
            t = x; x = y; y = t;
        end
        s.lo  = x;
        s.mid = y;
        s.hi  = z;
        return s;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        trio_t s;
        s = sort3(a, b, c);
        return s.mid;
    endfunction

endpackage

FILE: rtl/mf3_ram.sv
// generic single-write, single-read ram with registered read data
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/median_filter_3x3.sv
// top level of the streaming 3x3 median filter
//
//  channel   direction  beat carries
//  s_        in         pixel
//  m_        out        median, out_row, out_col, last_of_frame
//  cfg_      in         index, wdata (frame_width, frame_height)
//
// one pixel per cycle sustained while s_ready is high; a median reaches the output queue
// after its pixel passes the line-store read, window update and two compare stages
// the line stores are read at accept and written back the next cycle at the same column
// reset clears counters, window and queue; line-store contents are left as they are
// an 8-entry output queue with credit counting absorbs output stalls, s_ready drops
// only when 8 results are queued or in flight
module median_filter_3x3 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mf3_pkg::pix_t                    s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mf3_pkg::pix_t                    m_median,
    output logic [mf3_pkg::ROW_W-1:0]        m_out_row,
    output logic [mf3_pkg::COL_W-1:0]        m_out_col,
    output logic                             m_last_of_frame,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mf3_pkg::*;

    // configuration
    logic [FW_W-1:0]  frame_width_reg;
    logic [ROW_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters and beat classification
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [FW_W-1:0]  width_eff, width_m1;
    logic [ROW_W-1:0] height_eff, height_m1;
    logic             row_end, frame_end, has_result;
    logic             s_accept;

    always_comb begin
        width_eff = frame_width_reg;
        if (frame_width_reg < FW_MIN) begin
            width_eff = FW_MIN;
        end else if (frame_width_reg > FW_MAX) begin
            width_eff = FW_MAX;
        end
        height_eff = (frame_height_reg < FH_MIN) ? FH_MIN : frame_height_reg;
        width_m1   = width_eff - FW_W'(1);
        height_m1  = height_eff - ROW_W'(1);
        row_end    = {1'b0, col_reg} >= width_m1;
        frame_end  = row_end && (row_reg >= height_m1);
        has_result = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: a holds the previous row, b the one before
    logic [ADDR_W-1:0] rd_addr;
    pix_t              store_a_q, store_b_q;
    logic              p1_valid_reg;
    logic              p1_res_reg;
    pix_t              p1_px_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    meta_t             p1_meta_reg;

    assign rd_addr = col_reg[ADDR_W-1:0];

    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata (p1_px_reg),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (store_a_q)
    );

    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata (store_a_q),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (store_b_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_res_reg   <= 1'b0;
        end else begin
            p1_valid_reg <= s_accept;
            p1_res_reg   <= s_accept && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_px_reg        <= s_pixel;
            p1_addr_reg      <= rd_addr;
            p1_meta_reg.row  <= row_reg - ROW_W'(1);
            p1_meta_reg.col  <= col_reg - COL_W'(1);
            p1_meta_reg.last <= frame_end;
        end
    end

    // window: [column][line], column 2 newest, line 0 oldest
    pix_t  win_reg [3][3];
    logic  p2_res_reg;
    meta_t p2_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[c][r] <= '0;
                end
            end
            p2_res_reg <= 1'b0;
        end else begin
            p2_res_reg <= p1_res_reg;
            if (p1_valid_reg) begin
                win_reg[0]    <= win_reg[1];
                win_reg[1]    <= win_reg[2];
                win_reg[2][0] <= store_b_q;
                win_reg[2][1] <= store_a_q;
                win_reg[2][2] <= p1_px_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p2_meta_reg <= p1_meta_reg;
    end

    // median of nine: sort columns, then max of lows, median of mids, min of highs, and the median of those three
    trio_t p3_col_reg [3];
    logic  p3_res_reg;
    meta_t p3_meta_reg;
    pix_t  p4_lo_reg, p4_mid_reg, p4_hi_reg;
    logic  p4_res_reg;
    meta_t p4_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_res_reg <= 1'b0;
            p4_res_reg <= 1'b0;
        end else begin
            p3_res_reg <= p2_res_reg;
            p4_res_reg <= p3_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            p3_col_reg[c] <= sort3(win_reg[c][0], win_reg[c][1], win_reg[c][2]);
        end
        p3_meta_reg <= p2_meta_reg;
        p4_lo_reg   <= max3(p3_col_reg[0].lo, p3_col_reg[1].lo, p3_col_reg[2].lo);
        p4_mid_reg  <= med3(p3_col_reg[0].mid, p3_col_reg[1].mid, p3_col_reg[2].mid);
        p4_hi_reg   <= min3(p3_col_reg[0].hi, p3_col_reg[1].hi, p3_col_reg[2].hi);
        p4_meta_reg <= p3_meta_reg;
    end

    // output queue with credit count over queued and in-flight results
    result_t             fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  fifo_cnt_reg, fifo_cnt_next;
    logic [FIFO_CW-1:0]  credit_reg, credit_next;
    logic                push, pop;
    result_t             push_data;

    assign s_ready  = credit_reg < FIFO_CW'(FIFO_DEPTH);
    assign s_accept = s_valid && s_ready;
    assign push     = p4_res_reg;
    assign m_valid  = fifo_cnt_reg != '0;
    assign pop      = m_valid && m_ready;

    always_comb begin
        push_data.median = med3(p4_lo_reg, p4_mid_reg, p4_hi_reg);
        push_data.meta   = p4_meta_reg;
        fifo_cnt_next    = fifo_cnt_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        credit_next      = credit_reg + FIFO_CW'(s_accept && has_result) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign m_median        = fifo_reg[rd_ptr_reg].median;
    assign m_out_row       = fifo_reg[rd_ptr_reg].meta.row;
    assign m_out_col       = fifo_reg[rd_ptr_reg].meta.col;
    assign m_last_of_frame = fifo_reg[rd_ptr_reg].meta.last;

endmodule

FILE: rtl/mf3_checker.sv
// port-level checks for the 3x3 median filter, bound to the top level
module mf3_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input mf3_pkg::pix_t              m_median,
    input logic [mf3_pkg::ROW_W-1:0]  m_out_row,
    input logic [mf3_pkg::COL_W-1:0]  m_out_col,
    input logic                       m_last_of_frame
);
    import mf3_pkg::*;

    logic             have_prev_reg;
    logic [ROW_W-1:0] prev_row_reg;
    logic [COL_W-1:0] prev_col_reg;
    logic             prev_last_reg;
    logic             m_beat;

    assign m_beat = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (m_beat) begin
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_beat) begin
            prev_row_reg  <= m_out_row;
            prev_col_reg  <= m_out_col;
            prev_last_reg <= m_last_of_frame;
        end
    end

    // queue is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_median) && $stable(m_out_row)
                                && $stable(m_out_col) && $stable(m_last_of_frame))
        else $error("result changed while stalled");

    // within a row, centres step one column per beat
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && have_prev_reg && !prev_last_reg && (m_out_row == prev_row_reg)
        |-> m_out_col == prev_col_reg + COL_W'(1))
        else $error("column sequence broken");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_median        (m_median),
    .m_out_row       (m_out_row),
    .m_out_col       (m_out_col),
    .m_last_of_frame (m_last_of_frame)
);

FILE: tb/median_filter_3x3_test.sv
// self-checking testbench for the streaming 3x3 median filter
`timescale 1ns / 1ps

module median_filter_3x3_test;
    import mf3_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PIXELS = 250;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_NARROW} pix_mix_e;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    pix_t                   s_pixel;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    pix_t                   m_median;
    logic [ROW_W-1:0]       m_out_row;
    logic [COL_W-1:0]       m_out_col;
    logic                   m_last_of_frame;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // filter state as the block should hold it
    pix_t             line_a [MAX_WIDTH];
    pix_t             line_b [MAX_WIDTH];
    pix_t             win [9];
    logic [COL_W-1:0] col_cnt;
    logic [ROW_W-1:0] row_cnt;
    logic [FW_W-1:0]  cfg_width;
    logic [ROW_W-1:0] cfg_height;
    result_t          pending_medians [$];

    int  errors;
    int  pixels_sent;
    int  cycle_count;
    int  ready_hold;
    int  ready_roll;
    bit  steady_tx;

    median_filter_3x3 u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median        (m_median),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_of_frame (m_last_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("median_filter_3x3_test NOT OK");
            $finish;
        end
    end

    // output back-pressure: runs of ready, short stalls and the odd long one
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(0, 6);
            end else if (ready_roll < 62) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(50, 200);
            end else if (ready_roll < 95) begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(8, 30);
            end
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d, want %0d", what, got, want);
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                report_mismatch("result with none pending, median", m_median, 0);
            end else begin
                want = pending_medians.pop_front();
                if (m_median !== want.median)
                    report_mismatch("median", m_median, want.median);
                if (m_out_row !== want.meta.row)
                    report_mismatch("out_row", m_out_row, want.meta.row);
                if (m_out_col !== want.meta.col)
                    report_mismatch("out_col", m_out_col, want.meta.col);
                if (m_last_of_frame !== want.meta.last)
                    report_mismatch("last_of_frame", m_last_of_frame, want.meta.last);
            end
        end
    end

    function automatic pix_t median_of_window(input pix_t v [9]);
        pix_t s [9];
        pix_t t;
        s = v;
        for (int i = 0; i < 9; i++)
            for (int j = i + 1; j < 9; j++)
                if (s[i] > s[j]) begin
                    t = s[i];
                    s[i] = s[j];
                    s[j] = t;
                end
        return s[4];
    endfunction

    // one pixel through the line stores and window; queues the median it yields
    task automatic advance_window(input pix_t px, output bit frame_done);
        int      w;
        int      h;
        int      c;
        int      r;
        pix_t    top;
        pix_t    mid;
        bit      row_done;
        result_t res;
        w = int'(cfg_width);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(cfg_height);
        if (h < 3) h = 3;
        c = int'(col_cnt);
        r = int'(row_cnt);
        top = line_b[c];
        mid = line_a[c];
        line_b[c] = mid;
        line_a[c] = px;
        for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        row_done   = (c >= w - 1);
        frame_done = row_done && (r >= h - 1);
        if (r >= 2 && c >= 2) begin
            res.median    = median_of_window(win);
            res.meta.row  = ROW_W'(r - 1);
            res.meta.col  = COL_W'(c - 1);
            res.meta.last = frame_done;
            pending_medians.push_back(res);
        end
        if (row_done) begin
            col_cnt = '0;
            row_cnt = frame_done ? '0 : ROW_W'(r + 1);
        end else begin
            col_cnt = COL_W'(c + 1);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_tx || roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic pix_t pick_pixel(input pix_mix_e mix, input pix_t base);
        case (mix)
            MIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            MIX_NARROW:  return base + pix_t'($urandom_range(0, 3));
            default:     return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // valid stays up from one beat to the next when there is no gap
    task automatic send_pixel(input pix_t px, output bit frame_done);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        advance_window(px, frame_done);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count, input pix_mix_e mix);
        pix_t base;
        bit   done;
        base = pix_t'($urandom_range(0, 255));
        repeat (count) send_pixel(pick_pixel(mix, base), done);
    endtask

    task automatic send_until_frame_end(input pix_mix_e mix);
        pix_t base;
        bit   done;
        base = pix_t'($urandom_range(0, 255));
        done = 1'b0;
        while (!done) send_pixel(pick_pixel(mix, base), done);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_FRAME_WIDTH)
            cfg_width = data[FW_W-1:0];
        else
            cfg_height = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // hold the stream until every pending median is out and the pipe is empty
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // reset geometry 640x480 over two full rows and the start of a third,
    // then narrowed and cut short so the next pixel closes the frame
    task automatic test_reset_defaults();
        send_pixels(640, MIX_UNIFORM);
        send_pixels(640, MIX_EXTREME);
        send_pixels(20, MIX_NARROW);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'h0000);
        send_until_frame_end(MIX_UNIFORM);
    endtask

    // one-window frames: width 1 clamps to 3, upper data bits are ignored
    task automatic test_small_windows();
        pix_t shapes [6][9];
        bit   done;
        shapes = '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
                   '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
                   '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9},
                   '{8'd250, 8'd200, 8'd150, 8'd100, 8'd90, 8'd80, 8'd70, 8'd60, 8'd50},
                   '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255},
                   '{8'd7, 8'd3, 8'd9, 8'd3, 8'd7, 8'd9, 8'd7, 8'd3, 8'd9}};
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'hF801);
        write_reg(REG_FRAME_HEIGHT, 16'h0003);
        for (int f = 0; f < 6; f++)
            for (int p = 0; p < 9; p++)
                send_pixel(shapes[f][p], done);
    endtask

    // tallest height, then lowered below the current row part-way along a row
    task automatic test_height_change_mid_frame();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        send_pixels(4 * 5 + 2, MIX_UNIFORM);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_until_frame_end(MIX_NARROW);
    endtask

    // width shrunk below the current column, then widened again
    task automatic test_width_change_mid_frame();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'd12);
        write_reg(REG_FRAME_HEIGHT, 16'd6);
        send_pixels(2 * 12 + 8, MIX_UNIFORM);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'd5);
        send_pixels(5 + 2, MIX_UNIFORM);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'd40);
        send_until_frame_end(MIX_EXTREME);
    endtask

    task automatic test_random_frames();
        int       start;
        int       w;
        int       h;
        int       roll;
        int       cut;
        int       n;
        bit       done;
        pix_t     base;
        pix_mix_e mix;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            wait_idle();
            roll = $urandom_range(0, 99);
            if (roll < 5)       w = $urandom_range(0, 2);
            else if (roll < 60) w = $urandom_range(3, 8);
            else if (roll < 95) w = $urandom_range(9, 40);
            else                w = $urandom_range(41, 130);
            roll = $urandom_range(0, 99);
            if (roll < 8)       h = $urandom_range(0, 2);
            else if (roll < 85) h = $urandom_range(3, 6);
            else                h = $urandom_range(7, 12);
            if ($urandom_range(0, 1)) begin
                write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(w)});
                write_reg(REG_FRAME_HEIGHT, 16'(h));
            end else begin
                write_reg(REG_FRAME_HEIGHT, 16'(h));
                write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(w)});
            end
            if (w < 3) w = 3;
            if (h < 3) h = 3;
            mix       = pix_mix_e'($urandom_range(0, 2));
            base      = pix_t'($urandom_range(0, 255));
            steady_tx = ($urandom_range(0, 3) == 0);
            cut       = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h - 1) : -1;
            n         = 0;
            done      = 1'b0;
            while (!done) begin
                if (n == cut) begin
                    wait_idle();
                    roll = $urandom_range(0, 3);
                    // line stores are written up to column 639 by now, so widening is safe too
                    if (roll == 1)
                        write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'($urandom_range(0, 40))});
                    else if (roll >= 2)
                        write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
                end
                send_pixel(pick_pixel(mix, base), done);
                n++;
            end
        end
        steady_tx = 1'b0;
        wait_idle();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_pixel     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_FRAME_WIDTH;
        cfg_wdata   = '0;
        errors      = 0;
        pixels_sent = 0;
        cycle_count = 0;
        ready_hold  = 0;
        steady_tx   = 1'b0;
        foreach (line_a[i]) line_a[i] = '0;
        foreach (line_b[i]) line_b[i] = '0;
        foreach (win[i]) win[i] = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        cfg_width  = FW_RESET;
        cfg_height = FH_RESET;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_small_windows();
        test_height_change_mid_frame();
        test_width_change_mid_frame();
        test_random_frames();

        if (errors == 0)
            $display("median_filter_3x3_test OK");
        else
            $display("median_filter_3x3_test NOT OK");
        $finish;
    end

endmodule
